FILE: sv/tfl_pkg.sv
// Shared types and constants for the text frame to LCD command block.
`timescale 1ns / 1ps

package tfl_pkg;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_LENGTH = 3'd1,
    PH_OFFSET = 3'd2,
    PH_MARKER = 3'd3,
    PH_TEXT   = 3'd4
  } phase_t;

  localparam logic [7:0] CMD_SET_ADDR   = 8'h24;
  localparam logic [7:0] CMD_AUTO_WRITE = 8'hB0;
  localparam logic [7:0] CMD_AUTO_STOP  = 8'hB2;

  localparam logic [15:0] RST_TEXT_BASE   = 16'h0200;
  localparam logic [7:0]  RST_SYNC_BYTE   = 8'h55;
  localparam logic [3:0]  RST_SYNC_LENGTH = 4'd4;
  localparam logic [7:0]  RST_MARKER_BYTE = 8'h5D;

  localparam logic [1:0] REG_TEXT_BASE   = 2'd0;
  localparam logic [1:0] REG_SYNC_BYTE   = 2'd1;
  localparam logic [1:0] REG_SYNC_LENGTH = 2'd2;
  localparam logic [1:0] REG_MARKER_BYTE = 2'd3;

  localparam int MAX_RESULTS = 4;

  typedef struct packed {
    logic [15:0] text_base_address;
    logic [7:0]  sync_byte;
    logic [3:0]  sync_length;
    logic [7:0]  marker_byte;
  } cfg_t;

  typedef struct packed {
    logic       is_command;
    logic [7:0] bus_value;
  } result_t;

  // Results caused by one received byte, entry 0 goes out first.
  typedef struct packed {
    logic [2:0]                      count;
    result_t [MAX_RESULTS-1:0]       item;
  } burst_t;

endpackage

FILE: sv/tfl_decoder.sv
// Frame decoder: phase and counters, and the display writes one byte causes.
`timescale 1ns / 1ps

module tfl_decoder
  import tfl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output burst_t     burst
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] byte_count_r, byte_count_nxt;
  logic [7:0] text_length_r, text_length_nxt;
  logic [7:0] count_inc;
  logic [15:0] addr;

  assign count_inc = byte_count_r + 8'd1;
  assign addr      = cfg.text_base_address + {8'd0, rx_byte};

  always_comb begin
    phase_nxt       = phase_r;
    byte_count_nxt  = byte_count_r;
    text_length_nxt = text_length_r;
    burst           = '0;
    unique case (phase_r)
      PH_LENGTH: begin
        text_length_nxt = rx_byte;
        byte_count_nxt  = 8'd0;
        phase_nxt       = PH_OFFSET;
      end
      PH_OFFSET: begin
        burst.count   = 3'd4;
        burst.item[0] = '{is_command: 1'b0, bus_value: addr[7:0]};
        burst.item[1] = '{is_command: 1'b0, bus_value: addr[15:8]};
        burst.item[2] = '{is_command: 1'b1, bus_value: CMD_SET_ADDR};
        burst.item[3] = '{is_command: 1'b1, bus_value: CMD_AUTO_WRITE};
        phase_nxt     = PH_MARKER;
      end
      PH_MARKER: begin
        if (rx_byte == cfg.marker_byte) begin
          phase_nxt = PH_TEXT;
        end else begin
          burst.count    = 3'd1;
          burst.item[0]  = '{is_command: 1'b1, bus_value: CMD_AUTO_STOP};
          phase_nxt      = PH_HUNT;
          byte_count_nxt = 8'd0;
        end
      end
      PH_TEXT: begin
        burst.count    = 3'd1;
        burst.item[0]  = '{is_command: 1'b0, bus_value: rx_byte};
        byte_count_nxt = count_inc;
        // at least one data byte goes out even for a zero length
        if (count_inc >= text_length_r) begin
          burst.count    = 3'd2;
          burst.item[1]  = '{is_command: 1'b1, bus_value: CMD_AUTO_STOP};
          phase_nxt      = PH_HUNT;
          byte_count_nxt = 8'd0;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
        if (rx_byte == cfg.sync_byte) begin
          byte_count_nxt = count_inc;
          if (count_inc >= {4'd0, cfg.sync_length}) begin
            phase_nxt      = PH_LENGTH;
            byte_count_nxt = 8'd0;
          end
        end else begin
          byte_count_nxt = 8'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HUNT;
      byte_count_r  <= 8'd0;
      text_length_r <= 8'd0;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      byte_count_r  <= byte_count_nxt;
      text_length_r <= text_length_nxt;
    end
  end

endmodule

FILE: sv/text_frame_to_lcd_commands_core.sv
// Top level: configuration registers, frame decoder and result buffer.
`timescale 1ns / 1ps

// Turns received serial bytes into display bus writes. Each accepted byte is
// decoded in the cycle it is taken and its writes (zero to four) are loaded
// into a four-entry result buffer; they leave one per cycle on out_* while
// out_tready is high, the first one the cycle after the input transfer, tlast
// marking the last write caused by that byte. A new byte is taken while the
// buffer is empty or while its final entry is being taken, so the single
// output channel holds off the input until a byte's writes have drained.
// Configuration writes take effect on the next byte.
module text_frame_to_lcd_commands_core
  import tfl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // config port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] bus_value
  output logic        out_tuser,  // [0] is_command
  output logic        out_tlast
);

  cfg_t    cfg_r;
  burst_t  burst;
  result_t [MAX_RESULTS-1:0] buf_r, buf_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic in_xfer, out_xfer;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{text_base_address: RST_TEXT_BASE, sync_byte: RST_SYNC_BYTE,
                 sync_length: RST_SYNC_LENGTH, marker_byte: RST_MARKER_BYTE};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEXT_BASE:   cfg_r.text_base_address <= cfg_wdata;
        REG_SYNC_BYTE:   cfg_r.sync_byte         <= cfg_wdata[7:0];
        REG_SYNC_LENGTH: cfg_r.sync_length       <= cfg_wdata[3:0];
        REG_MARKER_BYTE: cfg_r.marker_byte       <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign out_tvalid = (cnt_r != 3'd0);
  assign out_xfer   = out_tvalid && out_tready;
  assign in_tready  = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_tready);
  assign in_xfer    = in_tvalid && in_tready;

  assign out_tdata = buf_r[0].bus_value;
  assign out_tuser = buf_r[0].is_command;
  assign out_tlast = (cnt_r == 3'd1);

  tfl_decoder u_decoder (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_xfer),
    .rx_byte (in_tdata),
    .cfg     (cfg_r),
    .burst   (burst)
  );

  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    if (in_xfer) begin
      buf_nxt = burst.item;
      cnt_nxt = burst.count;
    end else if (out_xfer) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        buf_nxt[i] = buf_r[i+1];
      end
      cnt_nxt = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4)
    else $error("result buffer count out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (cnt_r != 3'd0) |-> out_xfer && out_tlast)
    else $error("new byte loaded over pending results");

  a_drain_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && !in_xfer |=> cnt_r == $past(cnt_r) - 3'd1)
    else $error("result buffer did not advance by one");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> cnt_r == $past(cnt_r))
    else $error("result count changed while stalled");

endmodule

FILE: test/tb.sv
// Testbench for text_frame_to_lcd_commands_core: frames and noise checked against a predictor.
`timescale 1ns / 1ps

module tb
  import tfl_pkg::*;
;

  typedef struct {
    logic       is_command;
    logic [7:0] bus_value;
    logic       is_last;
  } lcd_write_t;

  // Mirrors the frame decoder and keeps the display writes still owed by the block.
  class lcd_write_scoreboard;
    logic [15:0] base_addr;
    logic [7:0]  sync_val;
    logic [3:0]  sync_len;
    logic [7:0]  marker;
    phase_t      ph;
    logic [7:0]  cnt;
    logic [7:0]  text_len;
    lcd_write_t  pending_q[$];
    lcd_write_t  burst_q[$];
    int          errors;

    function new();
      base_addr = RST_TEXT_BASE;
      sync_val  = RST_SYNC_BYTE;
      sync_len  = RST_SYNC_LENGTH;
      marker    = RST_MARKER_BYTE;
      ph        = PH_HUNT;
      cnt       = 8'd0;
      text_len  = 8'd0;
      errors    = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        REG_TEXT_BASE:   base_addr = val;
        REG_SYNC_BYTE:   sync_val  = val[7:0];
        REG_SYNC_LENGTH: sync_len  = val[3:0];
        REG_MARKER_BYTE: marker    = val[7:0];
        default: ;
      endcase
    endfunction

    function void add_write(logic cmd, logic [7:0] val);
      lcd_write_t w;
      w.is_command = cmd;
      w.bus_value  = val;
      w.is_last    = 1'b0;
      burst_q.push_back(w);
    endfunction

    function void note_byte(logic [7:0] b);
      logic [15:0] addr;
      burst_q.delete();
      case (ph)
        PH_LENGTH: begin
          text_len = b;
          cnt      = 8'd0;
          ph       = PH_OFFSET;
        end
        PH_OFFSET: begin
          addr = base_addr + {8'h00, b};
          add_write(1'b0, addr[7:0]);
          add_write(1'b0, addr[15:8]);
          add_write(1'b1, CMD_SET_ADDR);
          add_write(1'b1, CMD_AUTO_WRITE);
          ph = PH_MARKER;
        end
        PH_MARKER: begin
          if (b == marker) begin
            ph = PH_TEXT;
          end else begin
            add_write(1'b1, CMD_AUTO_STOP);
            ph  = PH_HUNT;
            cnt = 8'd0;
          end
        end
        PH_TEXT: begin
          add_write(1'b0, b);
          cnt = cnt + 8'd1;
          // zero length still writes one byte before the stop
          if (cnt >= text_len) begin
            add_write(1'b1, CMD_AUTO_STOP);
            ph  = PH_HUNT;
            cnt = 8'd0;
          end
        end
        default: begin
          ph = PH_HUNT;
          if (b == sync_val) begin
            cnt = cnt + 8'd1;
            if (cnt >= {4'h0, sync_len}) begin
              ph  = PH_LENGTH;
              cnt = 8'd0;
            end
          end else begin
            cnt = 8'd0;
          end
        end
      endcase
      if (burst_q.size() > 0) burst_q[burst_q.size()-1].is_last = 1'b1;
      foreach (burst_q[i]) pending_q.push_back(burst_q[i]);
    endfunction

    function void check_write(logic user, logic [7:0] data, logic tl);
      lcd_write_t w;
      if (pending_q.size() == 0) begin
        $error("unexpected write: is_command=%0d bus_value=%02h last=%0d", user, data, tl);
        errors++;
        return;
      end
      w = pending_q.pop_front();
      if (user !== w.is_command) begin
        $error("is_command mismatch: expected %0d, actual %0d", w.is_command, user);
        errors++;
      end
      if (data !== w.bus_value) begin
        $error("bus_value mismatch: expected %02h, actual %02h", w.bus_value, data);
        errors++;
      end
      if (tl !== w.is_last) begin
        $error("last mismatch: expected %0d, actual %0d", w.is_last, tl);
        errors++;
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = REG_TEXT_BASE;
  logic [15:0] cfg_wdata  = 16'h0000;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;  // [7:0] bus_value
  logic        out_tuser;  // [0] is_command
  logic        out_tlast;

  lcd_write_scoreboard sb = new();

  bit in_idle_on    = 1'b1;
  bit out_idle_on   = 1'b1;
  bit long_hold_req = 1'b0;
  int useful_items  = 0;

  text_frame_to_lcd_commands_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] rx_byte
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [7:0] bus_value
    .out_tuser  (out_tuser),  // [0] is_command
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int gap_len(bit on);
    int r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int g;
    bit ignored;
    g = gap_len(in_idle_on);
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    ignored = (sb.ph == PH_HUNT) && (b != sb.sync_val);
    sb.note_byte(b);
    if (!ignored) useful_items++;
  endtask

  // drop valid, wait for every owed write, then let header-only bytes finish decoding
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic send_frame();
    int kind, n, len;
    logic [7:0] s;
    s    = sb.sync_val;
    n    = (sb.sync_len == 4'd0) ? 1 : int'(sb.sync_len);
    kind = $urandom_range(0, 99);
    if (kind < 7) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      return;
    end
    // flush a partial hunt count so the header lands as planned
    if (sb.ph != PH_HUNT || sb.cnt != 8'd0) send_byte(s ^ 8'h01);
    if (kind < 15) begin
      if (n > 1) repeat ($urandom_range(1, n - 1)) send_byte(s);
      send_byte(s ^ 8'($urandom_range(1, 255)));
      return;
    end
    repeat (n) send_byte(s);
    if (kind < 25) begin
      send_byte(8'($urandom_range(0, 255)));
      send_byte(8'($urandom_range(0, 255)));
      send_byte(sb.marker ^ 8'($urandom_range(1, 255)));
      return;
    end
    len = $urandom_range(0, 99);
    if (len < 85)      len = $urandom_range(0, 4);
    else if (len < 97) len = $urandom_range(5, 20);
    else               len = $urandom_range(21, 60);
    send_byte(8'(len));
    send_byte(8'($urandom_range(0, 255)));
    send_byte(sb.marker);
    repeat ((len == 0) ? 1 : len) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin : result_sink
    int hold_cnt;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        sb.check_write(out_tuser, out_tdata, out_tlast);
        hold_cnt = gap_len(out_idle_on);
      end
      if (long_hold_req) begin
        hold_cnt      = 120;
        long_hold_req = 1'b0;
      end
      if (hold_cnt > 0) begin
        out_tready <= 1'b0;
        hold_cnt--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int phase_end;
    int r;
    logic [3:0] len4;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: a non-sync byte clears the count, then a zero-length frame
    send_byte(8'h55);
    send_byte(8'h55);
    send_byte(8'h13);
    repeat (4) send_byte(8'h55);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5D);
    send_byte(8'h00);
    settle();

    // zero sync length, address wrap past 0xFFFF, wrong marker
    write_reg(REG_TEXT_BASE, 16'hFFF0);
    write_reg(REG_SYNC_BYTE, 16'hFFFF);
    write_reg(REG_SYNC_LENGTH, 16'hFFF0);
    write_reg(REG_MARKER_BYTE, 16'h0000);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h20);
    send_byte(8'hFF);
    settle();

    // sync length lowered while hunting
    write_reg(REG_TEXT_BASE, 16'h0000);
    write_reg(REG_SYNC_LENGTH, 16'h000F);
    write_reg(REG_MARKER_BYTE, 16'h00FF);
    repeat (3) send_byte(8'hFF);
    settle();
    write_reg(REG_SYNC_LENGTH, 16'h0002);
    send_byte(8'hFF);
    send_byte(8'h02);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h80);
    settle();

    // random part; first phase has the sink hold off while the source keeps going
    write_reg(REG_SYNC_BYTE, 16'h0000);
    write_reg(REG_SYNC_LENGTH, 16'h0001);
    useful_items  = 0;
    in_idle_on    = 1'b0;
    out_idle_on   = 1'b0;
    long_hold_req = 1'b1;
    phase_end     = 45;
    while (useful_items < 280) begin
      send_frame();
      if (useful_items >= phase_end) begin
        settle();
        phase_end = useful_items + 45;
        r = $urandom_range(0, 3);
        write_reg(REG_TEXT_BASE, (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF :
                  16'($urandom_range(0, 65535)));
        r = $urandom_range(0, 3);
        write_reg(REG_SYNC_BYTE, {8'($urandom), (r == 0) ? 8'h00 : (r == 1) ? 8'hFF :
                  8'($urandom_range(0, 255))});
        case ($urandom_range(0, 9))
          0:       len4 = 4'd0;
          1:       len4 = 4'd15;
          default: len4 = 4'($urandom_range(1, 4));
        endcase
        write_reg(REG_SYNC_LENGTH, {12'($urandom), len4});
        write_reg(REG_MARKER_BYTE, {8'($urandom), 8'($urandom_range(0, 255))});
        in_idle_on  = ($urandom_range(0, 3) != 0);
        out_idle_on = ($urandom_range(0, 3) != 0);
      end
    end

    settle();
    repeat (12) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin : watchdog
    #8_000_000;
    $display("tb failed");
    $finish;
  end

endmodule
